// ===== rtl/sws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants for the stack with sorted insert
// Command and status codes, the data width, and the control bundle that the
// top level broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package sws_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 5;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell. insert covers both push and ordered insert;
   // front marks a push, which always opens the slot at the head.
   typedef struct packed {
      logic insert;
      logic front;
      logic pop;
      logic clear;
   } cell_ctrl_type;

endpackage : sws_pkg
`default_nettype wire

// ===== rtl/sws_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sws_cell: one slot of the ordered list
// Holds one value and its valid bit. On insert it either keeps its value,
// takes the new value, or takes its left neighbour's value; on pop it takes
// its right neighbour's value; on clear it drops its valid bit.
// ----------------------------------------------------------------------------
module sws_cell #(
   parameter bit HEAD = 1'b0
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  sws_pkg::cell_ctrl_type              ctrl,
   input  wire signed [sws_pkg::DATA_WIDTH-1:0] value,
   input  wire signed [sws_pkg::DATA_WIDTH-1:0] left_entry,
   input  wire                                 left_valid,
   input  wire                                 shift_in,
   input  wire signed [sws_pkg::DATA_WIDTH-1:0] right_entry,
   input  wire                                 right_valid,
   output logic signed [sws_pkg::DATA_WIDTH-1:0] entry_out,
   output logic                                valid_out,
   output logic                                shift_out
);

   logic signed [sws_pkg::DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                                  valid_ff, valid_in;
   logic                                  cmp;
   logic                                  here;
   logic                                  take;

   // At the head the new value goes only before a greater value (or on a push);
   // later slots go before a value that is not less than the new one.
   always_comb begin
      if (HEAD) begin
         cmp = ctrl.front | (entry_ff > value);
      end else begin
         cmp = (entry_ff >= value);
      end
      // An empty slot right after the last stored value is the end position.
      here      = valid_ff ? cmp : left_valid;
      take      = ~shift_in & here;
      shift_out = shift_in | take;
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert) begin
         if (shift_in) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else if (take) begin
            entry_in = value;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign valid_out = valid_ff;

endmodule : sws_cell
`default_nettype wire

// ===== rtl/stack_with_sorted_insert_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_sorted_insert_top: bounded list with push, pop and ordered insert
// A row of DEPTH cells holds the list, head at cell 0. Every request is
// handled by all cells at once and returns one response.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  request   req_command, req_value                   start high while busy low
//  response  rsp_status, rsp_popped_value, rsp_count  rsp_strobe, one cycle
//
// One request is taken in every cycle; busy is always low. The response
// appears in the cycle after the request and is held for that one cycle.
// The insertion point ripples through the cell row as a one-bit chain, which
// sets the clock period for large DEPTH. Reset empties the list at once.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module stack_with_sorted_insert_top #(
   parameter int DEPTH = sws_pkg::DEPTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire  [1:0]                             req_command,
   input  wire  signed [sws_pkg::DATA_WIDTH-1:0]  req_value,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic signed [sws_pkg::DATA_WIDTH-1:0]  rsp_popped_value,
   output logic [sws_pkg::COUNT_WIDTH-1:0]        rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [sws_pkg::DATA_WIDTH-1:0] entry [DEPTH];
   logic                                  valid [DEPTH];
   logic                                  shift [DEPTH];

   sws_pkg::cell_ctrl_type                ctrl;
   sws_pkg::status_type                   status;
   logic                                  accept;
   logic                                  full;
   logic                                  empty;
   logic [CW-1:0]                         count_ff, count_in;
   logic                                  strobe_ff, strobe_in;
   logic [1:0]                            status_ff, status_in;
   logic signed [sws_pkg::DATA_WIDTH-1:0] popped_ff, popped_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctrl      = '0;
      status    = sws_pkg::ST_DONE;
      count_in  = count_ff;
      popped_in = '0;
      if (accept) begin
         case (sws_pkg::command_type'(req_command))
            sws_pkg::CMD_PUSH, sws_pkg::CMD_INSERT: begin
               if (full) begin
                  status = sws_pkg::ST_FULL;
               end else begin
                  ctrl.insert = 1'b1;
                  ctrl.front  = (req_command == sws_pkg::CMD_PUSH);
                  count_in    = count_ff + CW'(1);
               end
            end
            sws_pkg::CMD_POP: begin
               if (empty) begin
                  status = sws_pkg::ST_EMPTY;
               end else begin
                  ctrl.pop  = 1'b1;
                  popped_in = entry[0];
                  count_in  = count_ff - CW'(1);
               end
            end
            sws_pkg::CMD_CLEAR: begin
               ctrl.clear = 1'b1;
               count_in   = '0;
            end
            default: begin
               status = sws_pkg::ST_DONE;
            end
         endcase
      end
      strobe_in = accept;
      status_in = status;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [sws_pkg::DATA_WIDTH-1:0] left_entry;
         logic                                  left_valid;
         logic                                  shift_in;
         logic signed [sws_pkg::DATA_WIDTH-1:0] right_entry;
         logic                                  right_valid;

         if (i == 0) begin : g_head
            assign left_entry = req_value;
            assign left_valid = 1'b1;
            assign shift_in   = 1'b0;
         end else begin : g_body
            assign left_entry = entry[i-1];
            assign left_valid = valid[i-1];
            assign shift_in   = shift[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_entry = '0;
            assign right_valid = 1'b0;
         end else begin : g_inner
            assign right_entry = entry[i+1];
            assign right_valid = valid[i+1];
         end

         sws_cell #(
            .HEAD (i == 0)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .value       (req_value),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .shift_in    (shift_in),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .entry_out   (entry[i]),
            .valid_out   (valid[i]),
            .shift_out   (shift[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_count        = sws_pkg::COUNT_WIDTH'(count_ff);

endmodule : stack_with_sorted_insert_top
`default_nettype wire
